// File: rtl/pidc_pkg.sv
// Shared types and constants of the PID/PWM controller.
package pidc_pkg;

	localparam int GAIN_W  = 32;
	localparam int ACC_W   = 32;
	localparam int CFG_W   = 32;
	localparam int IDX_W   = 2;
	localparam int DUTY_W  = 12;
	localparam int CMP_W   = 16;
	localparam int CMP_SHIFT = CMP_W - DUTY_W;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [DUTY_W-1:0] DUTY_MAX = 12'd4095;

	localparam logic [IDX_W-1:0] REG_TARGET = 2'd0;
	localparam logic [IDX_W-1:0] REG_PROP   = 2'd1;
	localparam logic [IDX_W-1:0] REG_INTEG  = 2'd2;
	localparam logic [IDX_W-1:0] REG_DERIV  = 2'd3;

	localparam logic [CFG_W-1:0] TARGET_RESET = 32'd2400;
	localparam logic [GAIN_W-1:0] PROP_RESET  = 32'd327680;
	localparam logic [GAIN_W-1:0] INTEG_RESET = 32'd197;
	localparam logic [GAIN_W-1:0] DERIV_RESET = 32'd0;

	typedef struct packed {
		logic signed [GAIN_W-1:0] prop;
		logic signed [GAIN_W-1:0] integ;
		logic signed [GAIN_W-1:0] deriv;
	} gains_t;

endpackage

// File: rtl/pid_pwm_controller.sv
// Top level of the clamped PID controller with PWM compare output.
//
// One converter sample enters per beat and one result leaves per beat; the
// block sustains one sample every clock cycle while out_stall is low. An
// accepted sample passes the four-entry queue, a register for the three
// gain products (32 by 32 at most), one for the Q16.16 scaling with
// truncation toward zero and saturation, and the output register that
// adds the terms and clamps the duty to 0..4095. The
// front end forms the error against target_level, updates the saturating
// error sum and the error difference, and stalls the input only when the
// queue is full; the back end stalls on its own behind out_stall. Write the
// registers (index 0 target_level, 1 prop_gain, 2 integ_gain,
// 3 deriv_gain_per_period) only while no sample is in flight.
module pid_pwm_controller
	import pidc_pkg::*;
#(
	parameter int SAMPLE_BITS    = 12,
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [IDX_W-1:0]           cfg_idx,
	input  logic [CFG_W-1:0]           cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [SAMPLE_BITS-1:0]     sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [DUTY_W-1:0]          duty,
	output logic [CMP_W-1:0]           compare_value,
	output logic signed [SAMPLE_BITS:0] error_now,
	output logic signed [GAIN_W-1:0]   prop_term,
	output logic signed [GAIN_W-1:0]   integ_term
);

	// queue entry: error, updated sum, error difference
	localparam int QW = 2 * SAMPLE_BITS + ACC_W + 3;

	gains_t          gains;
	logic            push;
	logic [QW-1:0]   push_data;
	logic            pop;
	logic            q_full;
	logic            q_not_empty;
	logic [QW-1:0]   q_data;

	// hold the input only when the queue has no room
	assign in_stall = q_full;

	pidc_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.sample    (sample),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data),
		.gains     (gains)
	);

	pidc_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop_data  (q_data)
	);

	pidc_back #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.gains         (gains),
		.q_not_empty   (q_not_empty),
		.q_data        (q_data),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.duty          (duty),
		.compare_value (compare_value),
		.error_now     (error_now),
		.prop_term     (prop_term),
		.integ_term    (integ_term)
	);

endmodule

// File: rtl/pidc_front.sv
// Front end: configuration registers, error, saturating error sum and difference.
module pidc_front
	import pidc_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [IDX_W-1:0]       cfg_idx,
	input  logic [CFG_W-1:0]       cfg_wdata,
	input  logic                   in_valid,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   q_full,
	output logic                   push,
	output logic [2*SAMPLE_BITS+ACC_W+2:0] push_data,
	output gains_t                 gains
);

	localparam int EW = SAMPLE_BITS + 1;

	logic [SAMPLE_BITS-1:0]  target_q;
	gains_t                  gains_q;
	logic signed [ACC_W-1:0] sum_q;
	logic signed [EW-1:0]    last_q;

	logic signed [EW-1:0]    err;
	logic signed [ACC_W:0]   sum_wide;
	logic signed [ACC_W-1:0] sum_next;
	logic signed [EW:0]      delta;

	assign push  = in_valid && !q_full;
	assign gains = gains_q;

	always_comb begin
		err      = $signed({1'b0, target_q}) - $signed({1'b0, sample});
		sum_wide = (ACC_W+1)'(sum_q) + (ACC_W+1)'(err);
		// clip to the signed 32-bit limits
		if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
			sum_next = {sum_wide[ACC_W], {(ACC_W-1){~sum_wide[ACC_W]}}};
		end else begin
			sum_next = sum_wide[ACC_W-1:0];
		end
		delta     = (EW+1)'(err) - (EW+1)'(last_q);
		push_data = {err, sum_next, delta};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q      <= TARGET_RESET[SAMPLE_BITS-1:0];
			gains_q.prop  <= PROP_RESET;
			gains_q.integ <= INTEG_RESET;
			gains_q.deriv <= DERIV_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_TARGET: target_q      <= cfg_wdata[SAMPLE_BITS-1:0];
				REG_PROP:   gains_q.prop  <= cfg_wdata[GAIN_W-1:0];
				REG_INTEG:  gains_q.integ <= cfg_wdata[GAIN_W-1:0];
				REG_DERIV:  gains_q.deriv <= cfg_wdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			last_q <= '0;
		end else if (push) begin
			sum_q  <= sum_next;
			last_q <= err;
		end
	end

endmodule

// File: rtl/pidc_queue.sv
// Small FIFO between the front end and the arithmetic back end.
module pidc_queue
	import pidc_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/pidc_back.sv
// Back end: gain products, scaling with saturation, sum and duty clamp.
module pidc_back
	import pidc_pkg::*;
#(
	parameter int SAMPLE_BITS    = 12,
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  gains_t                    gains,
	input  logic                      q_not_empty,
	input  logic [2*SAMPLE_BITS+ACC_W+2:0] q_data,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [DUTY_W-1:0]         duty,
	output logic [CMP_W-1:0]          compare_value,
	output logic signed [SAMPLE_BITS:0] error_now,
	output logic signed [GAIN_W-1:0]  prop_term,
	output logic signed [GAIN_W-1:0]  integ_term
);

	localparam int EW    = SAMPLE_BITS + 1;
	localparam int PW    = 2 * GAIN_W;
	localparam int TOT_W = GAIN_W + 2;
	localparam logic signed [TOT_W-1:0] TotMax = TOT_W'(DUTY_MAX);
	localparam logic signed [PW-1:0] RoundBias = (PW'(1) <<< GAIN_FRAC_BITS) - PW'(1);

	function automatic logic signed [GAIN_W-1:0] scale_sat(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] t;
		logic signed [GAIN_W-1:0] r;
		// bias negative products so the shift truncates toward zero
		t = (p + (p[PW-1] ? RoundBias : PW'(0))) >>> GAIN_FRAC_BITS;
		if (!t[PW-1] && (|t[PW-2:GAIN_W-1])) begin
			r = {1'b0, {(GAIN_W-1){1'b1}}};
		end else if (t[PW-1] && !(&t[PW-2:GAIN_W-1])) begin
			r = {1'b1, {(GAIN_W-1){1'b0}}};
		end else begin
			r = t[GAIN_W-1:0];
		end
		return r;
	endfunction

	logic signed [EW-1:0]    q_err;
	logic signed [ACC_W-1:0] q_sum;
	logic signed [EW:0]      q_delta;

	logic                    s1_valid;
	logic signed [EW-1:0]    err_s1;
	logic signed [PW-1:0]    pprod_s1;
	logic signed [PW-1:0]    iprod_s1;
	logic signed [PW-1:0]    dprod_s1;

	logic                    s2_valid;
	logic signed [EW-1:0]    err_s2;
	logic signed [GAIN_W-1:0] p_s2;
	logic signed [GAIN_W-1:0] i_s2;
	logic signed [GAIN_W-1:0] d_s2;

	logic                    out_v_q;
	logic [DUTY_W-1:0]       duty_q;
	logic signed [EW-1:0]    err_q;
	logic signed [GAIN_W-1:0] p_q;
	logic signed [GAIN_W-1:0] i_q;

	logic                    out_adv;
	logic                    s2_adv;
	logic                    s1_adv;
	logic signed [TOT_W-1:0] total;
	logic [DUTY_W-1:0]       duty_next;

	assign {q_err, q_sum, q_delta} = q_data;

	assign out_adv = !out_v_q || !out_stall;
	assign s2_adv  = !s2_valid || out_adv;
	assign s1_adv  = !s1_valid || s2_adv;
	assign pop     = q_not_empty && s1_adv;

	always_comb begin
		total = TOT_W'(p_s2) + TOT_W'(i_s2) + TOT_W'(d_s2);
		if (total[TOT_W-1]) begin
			duty_next = '0;
		end else if (total > TotMax) begin
			duty_next = DUTY_MAX;
		end else begin
			duty_next = total[DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (s1_adv) begin
				s1_valid <= q_not_empty;
			end
			if (s2_adv) begin
				s2_valid <= s1_valid;
			end
			if (out_adv) begin
				out_v_q <= s2_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			err_s1   <= q_err;
			pprod_s1 <= gains.prop * q_err;
			iprod_s1 <= gains.integ * q_sum;
			dprod_s1 <= gains.deriv * q_delta;
		end
		if (s2_adv && s1_valid) begin
			err_s2 <= err_s1;
			p_s2   <= scale_sat(pprod_s1);
			i_s2   <= scale_sat(iprod_s1);
			d_s2   <= scale_sat(dprod_s1);
		end
		if (out_adv && s2_valid) begin
			duty_q <= duty_next;
			err_q  <= err_s2;
			p_q    <= p_s2;
			i_q    <= i_s2;
		end
	end

	assign out_valid     = out_v_q;
	assign duty          = duty_q;
	assign compare_value = {duty_q, {CMP_SHIFT{1'b0}}};
	assign error_now     = err_q;
	assign prop_term     = p_q;
	assign integ_term    = i_q;

endmodule

// File: rtl/pidc_checker.sv
// Port-level assertions for the PID controller and their bind.
module pidc_assertions
	import pidc_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [DUTY_W-1:0]          duty,
	input logic [CMP_W-1:0]           compare_value,
	input logic signed [SAMPLE_BITS:0] error_now,
	input logic signed [GAIN_W-1:0]   prop_term,
	input logic signed [GAIN_W-1:0]   integ_term
);

	logic [3:0] pending_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && !in_stall;
	assign out_beat = out_valid && !out_stall;

	// count beats taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {3'd0, in_beat} - {3'd0, out_beat};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(duty) && $stable(error_now)
			&& $stable(prop_term) && $stable(integ_term))
		else $error("stalled result changed");

	a_cmp_scale: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> compare_value == {duty, {CMP_SHIFT{1'b0}}})
		else $error("compare value does not follow duty");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("result shown with no sample in flight");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> pending_q >= 4'(QUEUE_DEPTH))
		else $error("input stalled while queue has room");

endmodule

bind pid_pwm_controller pidc_assertions #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.duty          (duty),
	.compare_value (compare_value),
	.error_now     (error_now),
	.prop_term     (prop_term),
	.integ_term    (integ_term)
);

// File: tb/sv/pidc_checker.sv
// Checker for the PID/PWM controller: predicts each result and compares it with the output beat.
module pidc_checker
	import pidc_pkg::*;
#(
	parameter int SAMPLE_BITS    = 12,
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [IDX_W-1:0]            cfg_idx,
	input  logic [CFG_W-1:0]            cfg_wdata,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [SAMPLE_BITS-1:0]      sample,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [DUTY_W-1:0]           duty,
	input  logic [CMP_W-1:0]            compare_value,
	input  logic signed [SAMPLE_BITS:0] error_now,
	input  logic signed [GAIN_W-1:0]    prop_term,
	input  logic signed [GAIN_W-1:0]    integ_term,
	output int                          fail_count,
	output int                          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	typedef struct {
		logic [DUTY_W-1:0]           duty;
		logic [CMP_W-1:0]            cmp;
		logic signed [SAMPLE_BITS:0] err;
		logic signed [GAIN_W-1:0]    p;
		logic signed [GAIN_W-1:0]    i;
	} control_out_t;

	logic [SAMPLE_BITS-1:0] setpoint;
	longint kp, ki, kd;
	longint err_sum, prev_err;
	control_out_t pending_results[$];
	int mism = 0;
	int in_flight = 0;

	assign fail_count  = mism;
	assign outstanding = in_flight;

	function automatic longint clip_s32(longint x);
		if (x > S32_MAX)
			return S32_MAX;
		if (x < S32_MIN)
			return S32_MIN;
		return x;
	endfunction

	// scale down by the fraction bits, rounding toward zero
	function automatic longint scale_product(longint gain, longint value);
		longint prod;
		prod = gain * value;
		if (prod < 0)
			return clip_s32(-((-prod) >>> GAIN_FRAC_BITS));
		return clip_s32(prod >>> GAIN_FRAC_BITS);
	endfunction

	function automatic control_out_t next_control(logic [SAMPLE_BITS-1:0] smp);
		control_out_t res;
		longint e, p, i, d, total, lvl;
		e = longint'(setpoint) - longint'(smp);
		err_sum = clip_s32(err_sum + e);
		p = scale_product(kp, e);
		i = scale_product(ki, err_sum);
		d = scale_product(kd, e - prev_err);
		total = p + i + d;
		if (total < 0)
			lvl = 0;
		else if (total > longint'(DUTY_MAX))
			lvl = longint'(DUTY_MAX);
		else
			lvl = total;
		prev_err = e;
		res.duty = lvl[DUTY_W-1:0];
		res.cmp  = CMP_W'(lvl << CMP_SHIFT);
		res.err  = e[SAMPLE_BITS:0];
		res.p    = p[GAIN_W-1:0];
		res.i    = i[GAIN_W-1:0];
		return res;
	endfunction

	task automatic check_field(string fld, longint want, longint got);
		if (want != got) begin
			if (mism < 10)
				$display("%0s mismatch at %0t: expected %0d, got %0d", fld, $time, want, got);
			mism++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		control_out_t want;
		if (!arst_n) begin
			setpoint = TARGET_RESET[SAMPLE_BITS-1:0];
			kp = longint'($signed(PROP_RESET));
			ki = longint'($signed(INTEG_RESET));
			kd = longint'($signed(DERIV_RESET));
			err_sum = 0;
			prev_err = 0;
			pending_results.delete();
			in_flight <= 0;
		end else begin
			// retire the output beat first: it always belongs to an older sample
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					if (mism < 10)
						$display("unexpected result at %0t: duty %0d", $time, duty);
					mism++;
				end else begin
					want = pending_results.pop_front();
					check_field("duty", longint'(want.duty), longint'(duty));
					check_field("compare_value", longint'(want.cmp), longint'(compare_value));
					check_field("error_now", longint'(want.err), longint'(error_now));
					check_field("prop_term", longint'(want.p), longint'(prop_term));
					check_field("integ_term", longint'(want.i), longint'(integ_term));
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					REG_TARGET: setpoint = cfg_wdata[SAMPLE_BITS-1:0];
					REG_PROP:   kp = longint'($signed(cfg_wdata));
					REG_INTEG:  ki = longint'($signed(cfg_wdata));
					REG_DERIV:  kd = longint'($signed(cfg_wdata));
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				pending_results.push_back(next_control(sample));
			in_flight <= pending_results.size();
		end
	end

endmodule

// File: tb/sv/tb_pid_pwm_controller.sv
// Top of the PID/PWM controller testbench: clock, reset, stimulus, stall pattern and verdict.
module tb_pid_pwm_controller;
	timeunit 1ns;
	timeprecision 1ps;
	import pidc_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 400;
	localparam int ROUNDS         = 10;
	localparam int ROUND_ITEMS    = 100;
	// short full-rate run at the largest error
	localparam int SOAK_ITEMS     = 10;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [IDX_W-1:0]       cfg_idx = '0;
	logic [CFG_W-1:0]       cfg_wdata = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [11:0]            sample = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [DUTY_W-1:0]      duty;
	logic [CMP_W-1:0]       compare_value;
	logic signed [12:0]     error_now;
	logic signed [GAIN_W-1:0] prop_term;
	logic signed [GAIN_W-1:0] integ_term;
	int                     fail_count;
	int                     outstanding;

	// soak: full rate, no gaps on either side; burst: sender never idles
	bit soak = 1'b0;
	bit burst = 1'b0;
	bit hold_req = 1'b0;
	int quiet_cycles = 0;

	pid_pwm_controller i_dut (.*);

	pidc_checker i_check (.*);

	always #5 clk = ~clk;

	// Hold reset, then release it on a falling edge.
	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Mostly no gap, sometimes a short one, rarely a long pause.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [31:0] pick_gain();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3, 4: return $urandom;
			default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
		endcase
	endfunction

	// Favor samples near the setpoint so the loop spends time inside the
	// unclamped range; keep the rails and repeats for the derivative term.
	function automatic logic [11:0] pick_sample(logic [11:0] tgt, logic [11:0] prev);
		int r, v;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 12'($urandom);
		if (r < 70) begin
			v = int'(tgt) + int'($urandom_range(0, 128)) - 64;
			if (v < 0)
				v = 0;
			if (v > 4095)
				v = 4095;
			return 12'(v);
		end
		if (r < 80)
			return ($urandom_range(0, 1) != 0) ? 12'd4095 : 12'd0;
		return prev;
	endfunction

	// Offer one sample beat after an optional gap and hold it until accepted.
	// Valid only drops when a gap is taken, so it never toggles within a step.
	task automatic send_sample(input logic [11:0] s);
		int gap;
		gap = (soak || burst) ? 0 : idle_len();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		sample <= s;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Drop valid, wait for every predicted beat to come back, then let the
	// pipeline settle before any register write.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Write all four registers on consecutive edges, then drop the enable.
	task automatic set_regs(input logic [31:0] tgt, input logic [31:0] kp,
			input logic [31:0] ki, input logic [31:0] kd);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= REG_TARGET;
		cfg_wdata <= tgt;
		@(negedge clk);
		cfg_idx <= REG_PROP;
		cfg_wdata <= kp;
		@(negedge clk);
		cfg_idx <= REG_INTEG;
		cfg_wdata <= ki;
		@(negedge clk);
		cfg_idx <= REG_DERIV;
		cfg_wdata <= kd;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Receiver: alternate runs of ready and stalled cycles, with one long
	// hold-off on request so the block fills up and stalls its input.
	initial begin
		int run_left, stall_left, hold_left;
		bit hold_taken;
		run_left = 0;
		stall_left = 0;
		hold_left = 0;
		hold_taken = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (soak) begin
				out_stall <= 1'b0;
			end else if (run_left > 0) begin
				run_left--;
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				stall_left = idle_len();
				run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
					: $urandom_range(0, 12);
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: end the run if nothing moves on any port for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [31:0] tgt_word;
		logic [11:0] s;
		s = '0;
		wait (arst_n);
		repeat (2) @(negedge clk);

		// Reset settings: rails, the setpoint itself, alternating bit patterns.
		send_sample(12'd0);
		send_sample(12'd4095);
		send_sample(12'd2400);
		send_sample(12'd2400);
		send_sample(12'd1);
		send_sample(12'd4094);
		send_sample(12'hAAA);
		send_sample(12'h555);
		send_sample(12'd2400);
		drain();

		// Extreme gains; the setpoint word carries junk above its 12 bits.
		// Full swings hit the largest error difference for the derivative.
		set_regs(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_sample(12'd0);
		send_sample(12'd4095);
		send_sample(12'd0);
		send_sample(12'd4095);
		send_sample(12'd2048);
		drain();

		// Setpoint zero with high junk bits, gains of the opposite sign:
		// negative sums clamp the duty to zero, positive ones to full scale.
		set_regs(32'hFFFF_F000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_sample(12'd4095);
		send_sample(12'd0);
		send_sample(12'd4095);
		send_sample(12'd0);
		send_sample(12'd0);
		drain();

		// Random rounds, each with fresh settings; round three runs a burst
		// against the long receiver hold-off.
		for (int r = 0; r < ROUNDS; r++) begin
			tgt_word = $urandom;
			set_regs(tgt_word, pick_gain(), pick_gain(), pick_gain());
			burst = (r == 3) || ($urandom_range(0, 3) == 0);
			if (r == 3)
				hold_req = 1'b1;
			for (int k = 0; k < ROUND_ITEMS; k++) begin
				s = pick_sample(tgt_word[11:0], s);
				send_sample(s);
			end
			drain();
			burst = 1'b0;
		end

		// Full rate with the largest error: a big positive integral gain
		// first, then the most negative one so the integral term saturates
		// on both sides.
		soak = 1'b1;
		set_regs(32'd4095, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0);
		repeat (SOAK_ITEMS) send_sample(12'd0);
		drain();
		set_regs(32'd4095, 32'h0001_0000, 32'h8000_0000, 32'h0);
		repeat (SOAK_ITEMS + 50) send_sample(12'd0);
		drain();
		soak = 1'b0;

		// Negative errors pull the sum back down.
		set_regs(32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0000_4000);
		repeat (60) send_sample(12'($urandom_range(3000, 4095)));
		drain();

		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
